// ----- rtl/ssfe_pkg.sv -----
`timescale 1ns / 1ps
package ssfe_pkg;

	// Field widths
	localparam int KEY_BITS  = 64;
	localparam int KEY_W     = 64;
	localparam int NUM_W     = 32;
	localparam int CHAR_W    = 8;
	localparam int DIGITS    = 10;
	localparam int BCD_W     = 4 * DIGITS;
	localparam int DIG_W     = $clog2(DIGITS + 1);
	localparam int CONV_W    = $clog2(NUM_W);
	localparam int ROM_DEPTH = 64;
	localparam int IDX_W     = $clog2(ROM_DEPTH);

	// Keys at or above KEY_BITS are ignored
	localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} :
		((KEY_W'(1) << KEY_BITS) - KEY_W'(1));

	// Frame characters
	localparam logic [CHAR_W-1:0] CH_OPEN   = "<";
	localparam logic [CHAR_W-1:0] CH_SEP    = "/";
	localparam logic [CHAR_W-1:0] CH_CLOSE  = ">";
	localparam logic [CHAR_W-1:0] CH_WEIGHT = "f";
	localparam logic [CHAR_W-1:0] CH_ZERO   = "0";
	localparam logic [CHAR_W-1:0] CH_NONE   = 8'h00;

	// Key letter table, zero means the key gives no letter
	localparam logic [CHAR_W-1:0] KEY_ROM [ROM_DEPTH] = '{
		"S", "C", "T", "K", "P", "W", "H", "R",
		"A", "O", "~", "~", "*", "*", "E", "U",
		"F", "Q", "N", "B", "L", "G", "Y", "X",
		"D", "Z", "#", "#", "#", "#", "#", "#",
		"#", "#", "#", "#", "#", "#", "^", "+",
		"!", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV,
		ST_OPEN,
		ST_CNT_SKIP,
		ST_CNT_DIG,
		ST_SEP1,
		ST_SCAN,
		ST_SEP2,
		ST_TIM_SKIP,
		ST_TIM_DIG,
		ST_CLOSE
	} state_t;

	typedef enum logic [2:0] {
		SEL_OPEN,
		SEL_SEP,
		SEL_CNT,
		SEL_KEY,
		SEL_TIM,
		SEL_CLOSE
	} chsel_t;

	typedef struct packed {
		logic   take;
		logic   load;
		logic   conv;
		logic   emit;
		chsel_t sel;
		logic   cnt_shift;
		logic   tim_shift;
		logic   scan;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic trig;
		logic conv_done;
		logic cnt_zero;
		logic cnt_last;
		logic tim_zero;
		logic tim_last;
		logic hit;
		logic scan_last;
		logic slot_free;
	} status_t;

	// One double-dabble step: add 3 to digits of 5 or more, then shift in b
	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic b);
		logic [BCD_W-1:0] adj;
		adj = bcd;
		for (int d = 0; d < DIGITS; d++) begin
			if (adj[4*d +: 4] >= 4'd5)
				adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
		end
		return {adj[BCD_W-2:0], b};
	endfunction

endpackage

// ----- rtl/ssfe_in_if.sv -----
`timescale 1ns / 1ps
interface ssfe_in_if;
	import ssfe_pkg::*;

	logic             valid;
	logic             ready;
	logic             is_trigger;
	logic [KEY_W-1:0] key_state;
	logic [NUM_W-1:0] time_ms;

	modport source (output valid, output is_trigger, output key_state, output time_ms,
		input ready);
	modport sink (input valid, input is_trigger, input key_state, input time_ms,
		output ready);
endinterface

// ----- rtl/ssfe_out_if.sv -----
`timescale 1ns / 1ps
interface ssfe_out_if;
	import ssfe_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] first_char;
	logic [CHAR_W-1:0] second_char;
	logic              second_valid;
	logic              last;

	modport source (output valid, output first_char, output second_char,
		output second_valid, output last, input ready);
	modport sink (input valid, input first_char, input second_char,
		input second_valid, input last, output ready);
endinterface

// ----- rtl/steno_stroke_frame_encoder.sv -----
`timescale 1ns / 1ps
// Steno stroke frame encoder.
// stroke channel: one word per stroke (is_trigger, key_state, time_ms).
// A word with is_trigger low is taken and produces nothing.
// A trigger word produces one ASCII frame on the frame channel, one
// character per word: '<', stroke count, '/', key letters, '/', time, '>'.
// Key letter words carry 'f' in second_char with second_valid set; the
// closing '>' word has last set.
// After a trigger is accepted, both numbers are converted from binary to
// BCD together; then come '<', the count digits once their leading zeros
// are skipped, '/', the scan of all 64 key positions, '/', the time digits
// once their leading zeros are skipped, and '>'. Key positions without a
// letter still take a scan step; the key scan is the longest step. The
// first word, '<', is loaded once the conversion is done. Once '>' is
// loaded the controller returns to idle and the next stroke is taken.
// Output stalls hold the current word in the output register and pause the
// sequence; the next stroke is taken while the closing '>' still waits.
// Reset clears the stroke counter to zero and empties the output register.
module steno_stroke_frame_encoder (
	input  logic       clk,
	input  logic       arst_n,
	ssfe_in_if.sink    stroke,
	ssfe_out_if.source frame
);
	import ssfe_pkg::*;

	cmd_t    cmd;
	status_t sts;

	ssfe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	ssfe_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.stroke (stroke),
		.frame  (frame),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ----- rtl/ssfe_ctrl.sv -----
`timescale 1ns / 1ps
module ssfe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  ssfe_pkg::status_t sts,
	output ssfe_pkg::cmd_t    cmd
);
	import ssfe_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.sel       = SEL_OPEN;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (sts.in_valid && sts.trig) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
				if (sts.conv_done)
					state_d = ST_OPEN;
			end
			ST_OPEN: begin
				cmd.sel = SEL_OPEN;
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_CNT_SKIP;
				end
			end
			ST_CNT_SKIP: begin
				// drop leading zeros, keep at least one digit
				if (sts.cnt_zero && !sts.cnt_last)
					cmd.cnt_shift = 1'b1;
				else
					state_d = ST_CNT_DIG;
			end
			ST_CNT_DIG: begin
				cmd.sel = SEL_CNT;
				if (sts.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.cnt_shift = 1'b1;
					if (sts.cnt_last)
						state_d = ST_SEP1;
				end
			end
			ST_SEP1: begin
				cmd.sel = SEL_SEP;
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.sel = SEL_KEY;
				// a letter waits for the output slot, other keys pass at once
				if (!sts.hit || sts.slot_free) begin
					cmd.emit = sts.hit;
					cmd.scan = 1'b1;
					if (sts.scan_last)
						state_d = ST_SEP2;
				end
			end
			ST_SEP2: begin
				cmd.sel = SEL_SEP;
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_TIM_SKIP;
				end
			end
			ST_TIM_SKIP: begin
				if (sts.tim_zero && !sts.tim_last)
					cmd.tim_shift = 1'b1;
				else
					state_d = ST_TIM_DIG;
			end
			ST_TIM_DIG: begin
				cmd.sel = SEL_TIM;
				if (sts.slot_free) begin
					cmd.emit      = 1'b1;
					cmd.tim_shift = 1'b1;
					if (sts.tim_last)
						state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				cmd.sel = SEL_CLOSE;
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/ssfe_dp.sv -----
`timescale 1ns / 1ps
module ssfe_dp (
	input  logic              clk,
	input  logic              arst_n,
	ssfe_in_if.sink           stroke,
	ssfe_out_if.source        frame,
	input  ssfe_pkg::cmd_t    cmd,
	output ssfe_pkg::status_t sts
);
	import ssfe_pkg::*;

	logic [NUM_W-1:0]  stroke_cnt_q;
	logic [NUM_W-1:0]  bin_cnt_q, bin_tim_q;
	logic [BCD_W-1:0]  bcd_cnt_q, bcd_tim_q;
	logic [CONV_W-1:0] conv_n_q;
	logic [DIG_W-1:0]  dig_cnt_q, dig_tim_q;
	logic [KEY_W-1:0]  keys_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CHAR_W-1:0] prev_q;
	logic [CHAR_W-1:0] letter;
	logic [CHAR_W-1:0] char_d;

	logic              out_valid_q;
	logic [CHAR_W-1:0] first_q, second_q;
	logic              second_valid_q, last_q;

	assign stroke.ready = cmd.take;

	// Stroke counter, post-incremented per trigger
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stroke_cnt_q <= '0;
		else if (cmd.load)
			stroke_cnt_q <= stroke_cnt_q + NUM_W'(1);
	end

	// Binary to BCD, one bit per cycle for both numbers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_cnt_q <= stroke_cnt_q;
			bin_tim_q <= stroke.time_ms;
			bcd_cnt_q <= '0;
			bcd_tim_q <= '0;
			conv_n_q  <= '0;
			dig_cnt_q <= DIG_W'(DIGITS);
			dig_tim_q <= DIG_W'(DIGITS);
		end else begin
			if (cmd.conv) begin
				bin_cnt_q <= {bin_cnt_q[NUM_W-2:0], 1'b0};
				bin_tim_q <= {bin_tim_q[NUM_W-2:0], 1'b0};
				bcd_cnt_q <= dd_step(bcd_cnt_q, bin_cnt_q[NUM_W-1]);
				bcd_tim_q <= dd_step(bcd_tim_q, bin_tim_q[NUM_W-1]);
				conv_n_q  <= conv_n_q + CONV_W'(1);
			end
			// digit walk, most significant first
			if (cmd.cnt_shift) begin
				bcd_cnt_q <= {bcd_cnt_q[BCD_W-5:0], 4'd0};
				dig_cnt_q <= dig_cnt_q - DIG_W'(1);
			end
			if (cmd.tim_shift) begin
				bcd_tim_q <= {bcd_tim_q[BCD_W-5:0], 4'd0};
				dig_tim_q <= dig_tim_q - DIG_W'(1);
			end
		end
	end

	// Key scan in ascending order, one key per cycle unless a letter waits for the output slot
	assign letter = KEY_ROM[idx_q];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			keys_q <= stroke.key_state & KEY_MASK;
			idx_q  <= '0;
			prev_q <= CH_NONE;
		end else if (cmd.scan) begin
			keys_q <= {1'b0, keys_q[KEY_W-1:1]};
			idx_q  <= idx_q + IDX_W'(1);
			if (cmd.emit)
				prev_q <= letter;
		end
	end

	// Character select
	always_comb begin
		unique case (cmd.sel)
			SEL_OPEN:  char_d = CH_OPEN;
			SEL_SEP:   char_d = CH_SEP;
			SEL_CNT:   char_d = CH_ZERO | {4'd0, bcd_cnt_q[BCD_W-1 -: 4]};
			SEL_KEY:   char_d = letter;
			SEL_TIM:   char_d = CH_ZERO | {4'd0, bcd_tim_q[BCD_W-1 -: 4]};
			SEL_CLOSE: char_d = CH_CLOSE;
			default:   char_d = CH_NONE;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (frame.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			first_q        <= char_d;
			second_q       <= (cmd.sel == SEL_KEY) ? CH_WEIGHT : CH_NONE;
			second_valid_q <= (cmd.sel == SEL_KEY);
			last_q         <= (cmd.sel == SEL_CLOSE);
		end
	end

	assign frame.valid        = out_valid_q;
	assign frame.first_char   = first_q;
	assign frame.second_char  = second_q;
	assign frame.second_valid = second_valid_q;
	assign frame.last         = last_q;

	// Status to the controller
	always_comb begin
		sts.in_valid  = stroke.valid;
		sts.trig      = stroke.is_trigger;
		sts.conv_done = (conv_n_q == CONV_W'(NUM_W - 1));
		sts.cnt_zero  = (bcd_cnt_q[BCD_W-1 -: 4] == 4'd0);
		sts.cnt_last  = (dig_cnt_q == DIG_W'(1));
		sts.tim_zero  = (bcd_tim_q[BCD_W-1 -: 4] == 4'd0);
		sts.tim_last  = (dig_tim_q == DIG_W'(1));
		sts.hit       = keys_q[0] && (letter != CH_NONE) && (letter != prev_q);
		sts.scan_last = (idx_q == IDX_W'(ROM_DEPTH - 1));
		sts.slot_free = !out_valid_q || frame.ready;
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

	// Frame characters as the receiver expects them
	localparam logic [7:0] FR_OPEN   = "<";
	localparam logic [7:0] FR_SEP    = "/";
	localparam logic [7:0] FR_CLOSE  = ">";
	localparam logic [7:0] FR_WEIGHT = "f";
	localparam logic [7:0] FR_NONE   = 8'h00;

	localparam int MAX_GAP     = 14;
	localparam int LONG_HOLD   = 600;
	localparam int RAND_ITEMS  = 300;
	localparam int DRAIN_TICKS = 150;

	typedef struct packed {
		logic [7:0] first_char;
		logic [7:0] second_char;
		logic       second_valid;
		logic       last;
	} frame_word_t;

	// Builds the expected frame of each stroke and checks received words against it
	class stroke_frames;
		logic [7:0]  letter_tbl [64];
		logic [31:0] stroke_count;
		frame_word_t pending_chars [$];
		int          errors;
		int          chars_seen;
		int          frames_seen;
		int          idle_words;

		function new();
			string s;
			s = {"SCTKPWHR", "AO~~**EU", "FQNBLGYX", "DZ######", "######^+", "!"};
			for (int i = 0; i < 64; i++)
				letter_tbl[i] = (i < s.len()) ? s[i] : FR_NONE;
			stroke_count = '0;
			errors = 0;
			chars_seen = 0;
			frames_seen = 0;
			idle_words = 0;
		endfunction

		function void push_char(logic [7:0] c, bit is_letter, bit is_end);
			frame_word_t w;
			w.first_char   = c;
			w.second_char  = is_letter ? FR_WEIGHT : FR_NONE;
			w.second_valid = is_letter;
			w.last         = is_end;
			pending_chars.push_back(w);
		endfunction

		function void push_decimal(logic [31:0] v);
			string d;
			d = $sformatf("%0d", v);
			for (int i = 0; i < d.len(); i++)
				push_char(d[i], 1'b0, 1'b0);
		endfunction

		// Expected frame of one accepted stroke word
		function void note_stroke(bit trig, logic [63:0] keys, logic [31:0] tm);
			logic [7:0] prev;
			logic [7:0] c;
			if (!trig) begin
				idle_words++;
				return;
			end
			prev = FR_NONE;
			push_char(FR_OPEN, 1'b0, 1'b0);
			push_decimal(stroke_count);
			stroke_count = stroke_count + 32'd1;
			push_char(FR_SEP, 1'b0, 1'b0);
			// letters in key order, repeats of the previous letter dropped
			for (int i = 0; i < ssfe_pkg::KEY_BITS; i++) begin
				c = letter_tbl[i];
				if (keys[i] && c != FR_NONE && c != prev) begin
					push_char(c, 1'b1, 1'b0);
					prev = c;
				end
			end
			push_char(FR_SEP, 1'b0, 1'b0);
			push_decimal(tm);
			push_char(FR_CLOSE, 1'b0, 1'b1);
		endfunction

		function void check_char(frame_word_t got);
			frame_word_t want;
			if (pending_chars.size() == 0) begin
				errors++;
				if (errors <= 20)
					$display("%0t: unexpected frame word: char %h weight %h/%b last %b",
						$time, got.first_char, got.second_char, got.second_valid, got.last);
				return;
			end
			want = pending_chars.pop_front();
			chars_seen++;
			if (got.last)
				frames_seen++;
			if (got.first_char !== want.first_char || got.second_char !== want.second_char ||
				got.second_valid !== want.second_valid || got.last !== want.last) begin
				errors++;
				if (errors <= 20)
					$display("%0t: word mismatch: expected %h %h/%b %b, got %h %h/%b %b",
						$time,
						want.first_char, want.second_char, want.second_valid, want.last,
						got.first_char, got.second_char, got.second_valid, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ssfe_in_if  stroke_if ();
	ssfe_out_if frame_if ();

	stroke_frames frames;

	steno_stroke_frame_encoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stroke (stroke_if),
		.frame  (frame_if)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run guard
	initial begin
		#8_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// Offer one stroke word and wait until it is taken
	task automatic send_stroke(input bit trig, input logic [63:0] keys, input logic [31:0] tm,
		input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			stroke_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stroke_if.valid      <= 1'b1;
		stroke_if.is_trigger <= trig;
		stroke_if.key_state  <= keys;
		stroke_if.time_ms    <= tm;
		@(negedge clk);
		while (!stroke_if.ready) @(negedge clk);
		@(posedge clk);
		frames.note_stroke(trig, keys, tm);
	endtask

	// Frame receiver: random stalls, stall-free stretches, two long hold-offs
	initial begin
		int          stall;
		int          rx_words;
		frame_word_t got;
		rx_words = 0;
		frame_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_words == 20 || rx_words == 4000)
				stall = LONG_HOLD;
			else if ((rx_words / 150) % 3 == 1)
				stall = 0;
			else
				stall = $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				frame_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			frame_if.ready <= 1'b1;
			@(negedge clk);
			while (!frame_if.valid) @(negedge clk);
			got.first_char   = frame_if.first_char;
			got.second_char  = frame_if.second_char;
			got.second_valid = frame_if.second_valid;
			got.last         = frame_if.last;
			@(posedge clk);
			frames.check_char(got);
			rx_words++;
		end
	end

	// Reset, directed strokes, random strokes, drain
	initial begin
		logic [63:0] keys;
		logic [31:0] tm;
		logic [31:0] pow;
		bit          trig;
		frames = new();
		arst_n = 1'b0;
		stroke_if.valid      = 1'b0;
		stroke_if.is_trigger = 1'b0;
		stroke_if.key_state  = '0;
		stroke_if.time_ms    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, empty chord, repeats, keys without letters
		send_stroke(1'b0, '1, '1, 1'b0);
		send_stroke(1'b1, '0, 32'd0, 1'b0);
		send_stroke(1'b1, '1, 32'hFFFF_FFFF, 1'b0);
		send_stroke(1'b0, '0, 32'd0, 1'b0);
		send_stroke(1'b1, 64'h5555_5555_5555_5555, 32'd9, 1'b0);
		send_stroke(1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 32'd10, 1'b0);
		send_stroke(1'b1, 64'hFFFF_FE00_0000_0000, 32'd99, 1'b0);
		send_stroke(1'b1, 64'h0000_0000_0000_3C00, 32'd100, 1'b0);
		send_stroke(1'b1, 64'h0000_0000_0000_0C00, 32'd1, 1'b0);
		send_stroke(1'b1, 64'h0000_003F_FC00_0000, 32'd999_999_999, 1'b0);
		send_stroke(1'b1, 64'h0000_0000_0000_0001, 32'd1_000_000_000, 1'b0);
		send_stroke(1'b1, 64'h0000_0100_0000_0000, 32'd4_294_967_294, 1'b0);
		send_stroke(1'b1, 64'h8000_0000_0000_0000, 32'd12345, 1'b1);
		send_stroke(1'b1, 64'h0000_01FF_FFFF_FFFF, 32'd65536, 1'b1);
		send_stroke(1'b1, 64'h0000_0000_0280_0000, 32'd7, 1'b1);

		// random strokes with varied key density and number lengths
		for (int i = 0; i < RAND_ITEMS; i++) begin
			trig = ($urandom_range(0, 99) < 85);
			case ($urandom_range(0, 5))
				0: keys = {$urandom(), $urandom()};
				1: keys = {$urandom(), $urandom()} & {$urandom(), $urandom()} &
					{$urandom(), $urandom()};
				2: keys = {$urandom(), $urandom()} | {$urandom(), $urandom()};
				3: keys = 64'd1 << $urandom_range(0, 63);
				4: keys = {$urandom(), $urandom()} & 64'h0000_01FF_FFFF_FFFF;
				default: keys = $urandom_range(0, 1) ? '1 : '0;
			endcase
			case ($urandom_range(0, 3))
				0: tm = $urandom();
				1: tm = $urandom_range(0, 99);
				2: begin
					pow = 32'd1;
					repeat ($urandom_range(0, 9)) pow = pow * 32'd10;
					tm = pow - $urandom_range(0, 1);
				end
				default: tm = $urandom_range(32'hFFFF_FF00, 32'hFFFF_FFFF);
			endcase
			send_stroke(trig, keys, tm, (i / 40) % 3 == 2);
		end
		stroke_if.valid <= 1'b0;

		// let every frame arrive, then watch for stray words
		while (frames.pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);

		$display("summary: %0d trigger strokes and %0d idle words sent,",
			frames.stroke_count, frames.idle_words);
		$display("summary: %0d frames with %0d characters checked, %0d errors",
			frames.frames_seen, frames.chars_seen, frames.errors);
		if (frames.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
